// File: design/iad_pkg.sv
// ----------------------------------------------------------------------------
// iad_pkg
// Shared constants and types for the intrusion alarm detector.
// ----------------------------------------------------------------------------
package iad_pkg;

  localparam int EchoBitsDef = 20;
  localparam int PingBitsDef = 24;
  localparam int HitBits     = 8;
  localparam int CfgIdxBits  = 3;

  localparam int EchoWaitRst    = 100000;
  localparam int PingTimeoutRst = 2000000;
  localparam int HitLimitRst    = 3;

  localparam logic [CfgIdxBits-1:0] CFG_LOCAL_THR  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_SOUND_THR  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_ECHO_WAIT  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_PING_TMO   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_ARMED      = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_HIT_LIMIT  = 3'd5;

  typedef struct packed {
    logic done;
    logic local_on;
    logic alarm_set;
  } iad_meas_t;

  typedef struct packed {
    logic link_good;
    logic alarm_set;
  } iad_link_t;

endpackage

// File: design/iad_meas.sv
// ----------------------------------------------------------------------------
// iad_meas
// Echo measurement sequencer and intrusion confidence counter.
// ----------------------------------------------------------------------------
module iad_meas #(
  parameter int ECHO_BITS = iad_pkg::EchoBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        start_i,
  input  logic                        echo_i,
  input  logic [ECHO_BITS-1:0]        local_thr_i,
  input  logic [ECHO_BITS-1:0]        sound_thr_i,
  input  logic [ECHO_BITS-1:0]        echo_wait_i,
  input  logic [iad_pkg::HitBits-1:0] hit_limit_i,
  output iad_pkg::iad_meas_t          stat_o,
  output logic [ECHO_BITS-1:0]        ticks_o,
  output logic [iad_pkg::HitBits-1:0] conf_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;

  logic [1:0]                  phase_q, phase_d;
  logic [ECHO_BITS-1:0]        wait_q, wait_d;
  logic [ECHO_BITS-1:0]        count_q, count_d;
  logic [iad_pkg::HitBits-1:0] conf_q, conf_d, conf_inc;
  logic                        local_q, local_d;
  logic                        done, alarm_set;

  assign conf_inc = (conf_q == '1) ? conf_q : conf_q + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    wait_d    = wait_q;
    count_d   = count_q;
    conf_d    = conf_q;
    local_d   = local_q;
    done      = 1'b0;
    alarm_set = 1'b0;
    unique case (phase_q)
      PH_WAIT: begin
        if (echo_i) begin
          phase_d = PH_COUNT;
          count_d = {{(ECHO_BITS-1){1'b0}}, 1'b1};
        end else if (wait_q >= echo_wait_i) begin
          phase_d = PH_IDLE;
        end else begin
          wait_d = wait_q + 1'b1;
        end
      end
      PH_COUNT: begin
        if (echo_i) begin
          if (count_q != '1) count_d = count_q + 1'b1;
        end else begin
          done    = 1'b1;
          local_d = count_q < local_thr_i;
          phase_d = PH_IDLE;
          if (count_q < sound_thr_i) begin
            conf_d    = conf_inc;
            alarm_set = conf_inc > hit_limit_i;
          end else if (conf_q != '0) begin
            conf_d = conf_q - 1'b1;
          end
        end
      end
      default: begin
        if (start_i) begin
          phase_d = PH_WAIT;
          wait_d  = '0;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wait_q  <= '0;
      count_q <= '0;
      conf_q  <= '0;
      local_q <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      count_q <= count_d;
      conf_q  <= conf_d;
      local_q <= local_d;
    end
  end

  assign stat_o.done      = done;
  assign stat_o.local_on  = local_d;
  assign stat_o.alarm_set = alarm_set;
  assign ticks_o          = done ? count_q : '0;
  assign conf_o           = conf_d;

endmodule

// File: design/iad_link.sv
// ----------------------------------------------------------------------------
// iad_link
// Ping watchdog: tracks ping age and drops the link flag on silence.
// ----------------------------------------------------------------------------
module iad_link #(
  parameter int PING_BITS = iad_pkg::PingBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 ping_i,
  input  logic [PING_BITS-1:0] timeout_i,
  input  logic                 armed_i,
  output iad_pkg::iad_link_t   stat_o
);

  logic [PING_BITS-1:0] age_q, age_d;
  logic                 seen_q, seen_d;
  logic                 good_q, good_d;
  logic                 expire;

  always_comb begin
    if (ping_i)              age_d = '0;
    else if (age_q != '1)    age_d = age_q + 1'b1;
    else                     age_d = age_q;
    seen_d = seen_q | ping_i;
    expire = seen_d && (age_d > timeout_i);
    good_d = good_q & ~expire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q  <= '0;
      seen_q <= 1'b0;
      good_q <= 1'b1;
    end else if (en_i) begin
      age_q  <= age_d;
      seen_q <= seen_d;
      good_q <= good_d;
    end
  end

  assign stat_o.link_good = good_d;
  assign stat_o.alarm_set = expire & armed_i;

endmodule

// File: design/intrusion_alarm_detector.sv
// ----------------------------------------------------------------------------
// intrusion_alarm_detector
// Per-tick intrusion detector: echo ranging, confidence, vibration, watchdog.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sampled tick per beat.
//   Output channel (out_valid_o / out_stall_i) returns one result beat for
//   every input beat, in order, showing the state after that tick.
//   An accepted input beat passes the input register, then the result
//   register. Throughput: one beat per cycle while out_stall_i is low;
//   the state update is one pass of compare/increment logic between them.
//   A result waiting on a stalled receiver does not block the next input
//   beat from entering the input register; once both registers are full,
//   in_stall_o follows the receiver's stall.
//   Configuration: cfg_we_i writes register cfg_index_i in the cycle it is
//   high; write only while no beat is in flight. Unknown indexes are ignored.
//   Reset: clears both pipeline registers, detector state and loads the
//   configuration defaults; a beat in flight is dropped, none is invented.
// ----------------------------------------------------------------------------
module intrusion_alarm_detector #(
  parameter  int ECHO_BITS = iad_pkg::EchoBitsDef,
  parameter  int PING_BITS = iad_pkg::PingBitsDef,
  localparam int CFG_BITS  = (ECHO_BITS > PING_BITS) ? ECHO_BITS : PING_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_measure_i,
  input  logic                          echo_level_i,
  input  logic                          vibration_pin_i,
  input  logic                          ping_seen_i,
  input  logic                          toggle_request_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          local_alarm_o,
  output logic                          alarm_active_o,
  output logic                          link_ok_o,
  output logic                          measure_done_o,
  output logic [ECHO_BITS-1:0]          echo_ticks_o,
  output logic [iad_pkg::HitBits-1:0]   hit_count_o,
  input  logic                          cfg_we_i,
  input  logic [iad_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]           cfg_data_i
);

  logic [ECHO_BITS-1:0]        local_thr_q, sound_thr_q, echo_wait_q;
  logic [PING_BITS-1:0]        ping_tmo_q;
  logic                        armed_q;
  logic [iad_pkg::HitBits-1:0] hit_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_thr_q <= '0;
      sound_thr_q <= '0;
      echo_wait_q <= ECHO_BITS'(iad_pkg::EchoWaitRst);
      ping_tmo_q  <= PING_BITS'(iad_pkg::PingTimeoutRst);
      armed_q     <= 1'b1;
      hit_limit_q <= iad_pkg::HitBits'(iad_pkg::HitLimitRst);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        iad_pkg::CFG_LOCAL_THR: local_thr_q <= cfg_data_i[ECHO_BITS-1:0];
        iad_pkg::CFG_SOUND_THR: sound_thr_q <= cfg_data_i[ECHO_BITS-1:0];
        iad_pkg::CFG_ECHO_WAIT: echo_wait_q <= cfg_data_i[ECHO_BITS-1:0];
        iad_pkg::CFG_PING_TMO:  ping_tmo_q  <= cfg_data_i[PING_BITS-1:0];
        iad_pkg::CFG_ARMED:     armed_q     <= cfg_data_i[0];
        iad_pkg::CFG_HIT_LIMIT: hit_limit_q <= cfg_data_i[iad_pkg::HitBits-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic in_vld_q;
  logic start_q, echo_q, vib_q, ping_q, toggle_q;
  logic advance, in_take;

  assign advance    = in_vld_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      start_q  <= start_measure_i;
      echo_q   <= echo_level_i;
      vib_q    <= vibration_pin_i;
      ping_q   <= ping_seen_i;
      toggle_q <= toggle_request_i;
    end
  end

  iad_pkg::iad_meas_t          meas;
  iad_pkg::iad_link_t          link;
  logic [ECHO_BITS-1:0]        ticks;
  logic [iad_pkg::HitBits-1:0] conf;

  iad_meas #(.ECHO_BITS(ECHO_BITS)) u_meas (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .start_i     (start_q),
    .echo_i      (echo_q),
    .local_thr_i (local_thr_q),
    .sound_thr_i (sound_thr_q),
    .echo_wait_i (echo_wait_q),
    .hit_limit_i (hit_limit_q),
    .stat_o      (meas),
    .ticks_o     (ticks),
    .conf_o      (conf)
  );

  iad_link #(.PING_BITS(PING_BITS)) u_link (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .ping_i    (ping_q),
    .timeout_i (ping_tmo_q),
    .armed_i   (armed_q),
    .stat_o    (link)
  );

  // alarm latch: sets first, toggle last
  logic alarm_q, alarm_d;

  assign alarm_d = (alarm_q | meas.alarm_set | ~vib_q | link.alarm_set) ^ toggle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= 1'b0;
    end else if (advance) begin
      alarm_q <= alarm_d;
    end
  end

  // result register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      local_alarm_o  <= meas.local_on;
      alarm_active_o <= alarm_d;
      link_ok_o      <= link.link_good;
      measure_done_o <= meas.done;
      echo_ticks_o   <= ticks;
      hit_count_o    <= conf;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule
